// ===== design/mau_pkg.sv =====
`timescale 1ns / 1ps
package mau_pkg;
  localparam int DataWidthDefault = 32;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_POW = 3'd4,
    CMD_INV = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DISPATCH,
    ST_INV_DIV,
    ST_INV_MUL,
    ST_INV_STEP,
    ST_POST_INV,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_POW_NEXT,
    ST_MUL,
    ST_DONE
  } state_t;
endpackage

// ===== design/modular_arithmetic_unit_top.sv =====
`timescale 1ns / 1ps
// flow: both operands are reduced bit-serially, then add/sub finish at dispatch; multiply
// adds a shift-add pass; power adds square-and-multiply passes plus the inverse
// inverse: euclid rounds, each a bit-serial divide, a multiply and a step
// one word at a time: busy stays high until the strobe; start is ignored while busy
// the receiver cannot stall; rst clears control and sets the modulus to 2
module modular_arithmetic_unit_top import mau_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            cmd,
  input  logic signed [DATA_WIDTH-1:0] operand_a,
  input  logic signed [DATA_WIDTH-1:0] operand_b,
  input  logic                  cfg_we,
  input  logic [DATA_WIDTH-1:0] cfg_data,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result_value,
  output logic                  no_inverse
);
  localparam int W = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam logic [W-1:0] ONE = W'(1);
  localparam logic [W-1:0] TWO = W'(2);

  state_t state, state_next;

  logic [W-1:0] modulus_value, m;
  logic [2:0]   op;
  logic [W-1:0] a, b, eraw;
  logic         eneg;
  // serial divider / multiplier shared
  logic [W-1:0] dq, drem;   // dividend shifting out, partial remainder
  logic [W-1:0] mx, my, macc; // multiply: addend, multiplier bits, accumulator
  logic [CW-1:0] cnt;
  // euclid
  logic [W-1:0] r0, r1, t0, t1;
  logic [W-1:0] acc, base, ex;
  logic         err;
  logic         red_neg;

  always_comb m = (modulus_value < TWO) ? TWO : modulus_value;

  always_ff @(posedge clk) begin
    if (rst) modulus_value <= TWO;
    else if (cfg_we) modulus_value <= cfg_data;
  end

  assign busy = (state != ST_IDLE);

  // shift the next dividend bit into the partial remainder
  function automatic logic [W:0] div_trial(input logic [W-1:0] rem, input logic bitin);
    logic [W:0] s;
    s = {rem, bitin};
    return s;
  endfunction

  logic [W:0]   dshift;
  logic [W-1:0] ddiv;
  logic         dge;
  logic [W:0]   madd;
  logic [W-1:0] madd_r, mdbl_r;
  logic [W:0]   mdbl;
  logic [W-1:0] msub;

  always_comb begin
    ddiv   = (state == ST_INV_DIV) ? r1 : m;
    dshift = div_trial(drem, dq[W-1]);
    dge    = (dshift >= {1'b0, ddiv});
    madd   = {1'b0, macc} + {1'b0, mx};
    madd_r = (madd >= {1'b0, m}) ? W'(madd - {1'b0, m}) : madd[W-1:0];
    mdbl   = {mx, 1'b0};
    mdbl_r = (mdbl >= {1'b0, m}) ? W'(mdbl - {1'b0, m}) : mdbl[W-1:0];
    msub   = (t0 >= macc) ? (t0 - macc) : (t0 + (m - macc));
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = ST_RED_A;
      ST_RED_A:    if (cnt == CW'(W - 1)) state_next = ST_RED_B;
      ST_RED_B:    if (cnt == CW'(W - 1)) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (op)
          CMD_MUL: state_next = ST_MUL;
          CMD_DIV, CMD_INV: state_next = ST_INV_DIV;
          CMD_POW: state_next = eneg ? ST_INV_DIV : ST_POW_NEXT;
          default: state_next = ST_DONE;
        endcase
      end
      ST_INV_DIV:  state_next = (r1 == '0) ? ST_POST_INV
                              : ((cnt == CW'(W - 1)) ? ST_INV_MUL : ST_INV_DIV);
      ST_INV_MUL:  if (my == '0) state_next = ST_INV_STEP;
      ST_INV_STEP: state_next = ST_INV_DIV;
      ST_POST_INV: begin
        if (r0 != ONE) state_next = ST_DONE;
        else if (op == CMD_DIV) state_next = ST_MUL;
        else if (op == CMD_POW) state_next = ST_POW_NEXT;
        else state_next = ST_DONE;
      end
      ST_POW_NEXT: state_next = (ex == '0) ? ST_DONE : (ex[0] ? ST_POW_MUL : ST_POW_SQR);
      ST_POW_MUL:  if (my == '0) state_next = ST_POW_SQR;
      ST_POW_SQR:  if (my == '0) state_next = ST_POW_NEXT;
      ST_MUL:      if (my == '0) state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            op      <= cmd;
            eraw    <= operand_b;
            eneg    <= operand_b[W-1];
            b       <= operand_b;
            red_neg <= operand_a[W-1];
            dq      <= operand_a[W-1] ? W'(-operand_a) : operand_a;
            drem    <= '0;
            cnt     <= '0;
            err     <= 1'b0;
          end
        end
        // bit-serial remainder of |operand| by m, then fold negatives
        ST_RED_A, ST_RED_B: begin
          drem <= dge ? W'(dshift - {1'b0, m}) : dshift[W-1:0];
          dq   <= {dq[W-2:0], 1'b0};
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            cnt <= '0;
            if (state == ST_RED_A) begin
              a <= (red_neg && (dge ? W'(dshift - {1'b0, m}) : dshift[W-1:0]) != '0)
                   ? m - (dge ? W'(dshift - {1'b0, m}) : dshift[W-1:0])
                   : (dge ? W'(dshift - {1'b0, m}) : dshift[W-1:0]);
              red_neg <= b[W-1];
              dq      <= b[W-1] ? W'(-b) : b;
              drem    <= '0;
            end else begin
              b <= (red_neg && (dge ? W'(dshift - {1'b0, m}) : dshift[W-1:0]) != '0)
                   ? m - (dge ? W'(dshift - {1'b0, m}) : dshift[W-1:0])
                   : (dge ? W'(dshift - {1'b0, m}) : dshift[W-1:0]);
            end
          end
        end
        ST_DISPATCH: begin
          acc <= (m == ONE) ? '0 : ONE;
          ex  <= eneg ? W'(-eraw) : eraw;
          case (op)
            CMD_ADD: acc <= W'(({1'b0, a} + {1'b0, b} >= {1'b0, m})
                            ? {1'b0, a} + {1'b0, b} - {1'b0, m} : {1'b0, a} + {1'b0, b});
            CMD_SUB: acc <= (a >= b) ? a - b : a + (m - b);
            CMD_MUL: begin
              macc <= '0; mx <= a; my <= b;
            end
            CMD_POW: base <= a;
            default: acc <= '0;
          endcase
          // euclid seeds
          r0 <= m;
          r1 <= (op == CMD_DIV) ? b : a;
          t0 <= '0;
          t1 <= ONE;
          dq <= m;
          drem <= '0;
          cnt <= '0;
        end
        // quotient bits collect in dq, remainder in drem
        ST_INV_DIV: begin
          if (r1 != '0) begin
            drem <= dge ? W'(dshift - {1'b0, r1}) : dshift[W-1:0];
            dq   <= {dq[W-2:0], dge};
            cnt  <= cnt + 1'b1;
            if (cnt == CW'(W - 1)) begin
              // q mod m: q <= r0 <= m, so q==m only when r1==1 and r0==m
              my   <= ({dq[W-2:0], dge} == m) ? '0 : {dq[W-2:0], dge};
              mx   <= t1;
              macc <= '0;
              cnt  <= '0;
            end
          end
        end
        ST_INV_MUL, ST_POW_MUL, ST_POW_SQR, ST_MUL: begin
          if (my != '0) begin
            if (my[0]) macc <= madd_r;
            mx <= mdbl_r;
            my <= my >> 1;
          end else begin
            case (state)
              ST_POW_MUL: begin
                acc <= macc; macc <= '0; mx <= base; my <= base;
              end
              ST_POW_SQR: begin
                base <= macc; ex <= ex >> 1;
              end
              ST_MUL: acc <= macc;
              default: ;
            endcase
          end
        end
        ST_INV_STEP: begin
          r0 <= r1;
          r1 <= drem;
          t0 <= t1;
          t1 <= msub;
          dq <= r1;
          drem <= '0;
        end
        ST_POST_INV: begin
          if (r0 != ONE) begin
            err <= 1'b1;
            acc <= '0;
          end else if (op == CMD_DIV) begin
            macc <= '0; mx <= a; my <= t0;
          end else if (op == CMD_POW) begin
            base <= t0;
          end else begin
            acc <= t0;
          end
        end
        ST_POW_NEXT: begin
          if (ex != '0) begin
            macc <= '0;
            if (ex[0]) begin mx <= acc; my <= base; end
            else begin mx <= base; my <= base; end
          end
        end
        ST_DONE: begin
          done         <= 1'b1;
          result_value <= err ? '0 : acc;
          no_inverse   <= err;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== dv/modular_arithmetic_unit_checker.sv =====
`timescale 1ns / 1ps
module modular_arithmetic_unit_checker import mau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  cmd,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        done,
  input  logic [31:0] result_value,
  input  logic        no_inverse,
  output int          fail_count,
  output int          words_pending
);

  typedef struct packed {
    logic [31:0] value;
    logic        no_inv;
  } mod_result_t;

  mod_result_t result_queue[$];
  logic [31:0] modulus_q;

  // fold a signed word into 0..m-1
  function automatic longint fold_signed(input logic [31:0] raw, input longint m);
    longint mag;
    longint rem;
    if (!raw[31]) return longint'({32'b0, raw}) % m;
    mag = longint'({32'b0, ~raw}) + 1;
    rem = mag % m;
    return (rem == 0) ? 0 : m - rem;
  endfunction

  // extended euclid, returns 1 when the inverse exists
  function automatic logic find_inverse(input longint x, input longint m,
                                        output longint inv);
    longint r0, r1, t0, t1, q, nr, nt;
    r0 = m;
    r1 = x;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      nt = t0 - q * t1;
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    inv = 0;
    if (r0 != 1) return 1'b0;
    inv = (t0 < 0) ? t0 + m : t0 % m;
    return 1'b1;
  endfunction

  function automatic longint raise_power(input longint base, input longint e,
                                         input longint m);
    longint unsigned acc;
    longint unsigned b;
    acc = 1 % m;
    b   = base;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic mod_result_t predict_word(input logic [2:0] c, input logic [31:0] ra,
                                               input logic [31:0] rb, input logic [31:0] mreg);
    longint m, a, b, iv, e;
    longint unsigned prod;
    mod_result_t r;
    m = (mreg < 2) ? 2 : longint'({32'b0, mreg});
    a = fold_signed(ra, m);
    b = fold_signed(rb, m);
    r = '0;
    case (c)
      CMD_ADD: r.value = 32'((a + b) % m);
      CMD_SUB: r.value = 32'((a + m - b) % m);
      CMD_MUL: begin
        prod = longint'(a) * longint'(b);
        r.value = 32'(prod % m);
      end
      CMD_DIV: begin
        if (find_inverse(b, m, iv)) begin
          prod = longint'(a) * longint'(iv);
          r.value = 32'(prod % m);
        end else r.no_inv = 1'b1;
      end
      CMD_POW: begin
        if (rb[31]) begin
          e = longint'({32'b0, ~rb}) + 1;
          if (find_inverse(a, m, iv)) r.value = 32'(raise_power(iv, e, m));
          else r.no_inv = 1'b1;
        end else begin
          r.value = 32'(raise_power(a, longint'({32'b0, rb}), m));
        end
      end
      CMD_INV: begin
        if (find_inverse(a, m, iv)) r.value = 32'(iv);
        else r.no_inv = 1'b1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign words_pending = result_queue.size();

  // track the modulus, predict on accept, compare on strobe
  always @(posedge clk) begin
    mod_result_t exp_w;
    if (rst) begin
      modulus_q <= 32'd2;
      result_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) modulus_q <= cfg_data;
      if (start && !busy) result_queue.push_back(predict_word(cmd, operand_a, operand_b,
                                                              modulus_q));
      if (done) begin
        if (result_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", result_value);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = result_queue.pop_front();
          if (exp_w.value !== result_value || exp_w.no_inv !== no_inverse) begin
            if (fail_count < 10)
              $display("mismatch: expected value %h no_inverse %b, got %h %b",
                       exp_w.value, exp_w.no_inv, result_value, no_inverse);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/modular_arithmetic_unit_top_tb.sv =====
`timescale 1ns / 1ps
module modular_arithmetic_unit_top_tb import mau_pkg::*; ();

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  cmd;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        cfg_we;
  logic [31:0] cfg_data;
  logic        done;
  logic [31:0] result_value;
  logic        no_inverse;
  int          fail_count;
  int          words_pending;
  logic        no_gaps;

  modular_arithmetic_unit_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .operand_a(operand_a), .operand_b(operand_b), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .done(done), .result_value(result_value),
    .no_inverse(no_inverse)
  );

  modular_arithmetic_unit_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .operand_a(operand_a), .operand_b(operand_b), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .done(done), .result_value(result_value),
    .no_inverse(no_inverse), .fail_count(fail_count), .words_pending(words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #300_000_000;
    $display("modular_arithmetic_unit_top_tb failed");
    $finish;
  end

  // issue one word, start stays high on return
  task automatic issue_word(input logic [2:0] c, input logic [31:0] a, input logic [31:0] b);
    if (!no_gaps && $urandom_range(99) < 31) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start     <= 1'b1;
    cmd       <= c;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
  endtask

  // drain, then write the modulus while idle
  task automatic load_modulus(input logic [31:0] m);
    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 20));
      3: return -32'($urandom_range(1, 20));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_modulus();
    case ($urandom_range(6))
      0: return 32'hffff_ffff;
      1: return 32'hffff_fffb;
      2: return 32'($urandom_range(0, 3));
      3: return 32'($urandom_range(2, 60));
      4: return 32'd1_000_003;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          guard;
    logic [2:0]  c;
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = CMD_ADD;
    operand_a = '0;
    operand_b = '0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    no_gaps   = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset modulus of two, field extremes
    issue_word(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000);
    issue_word(CMD_SUB, 32'h0, 32'hffff_ffff);
    issue_word(CMD_INV, 32'h0, 32'h0);
    // composite modulus: shared factors and zero divisors
    load_modulus(32'd12);
    issue_word(CMD_MUL, 32'hffff_fff9, 32'd11);
    issue_word(CMD_DIV, 32'd5, 32'd6);
    issue_word(CMD_DIV, 32'd5, 32'd0);
    issue_word(CMD_DIV, 32'd7, 32'hffff_fffb);
    issue_word(CMD_INV, 32'd6, 32'd0);
    issue_word(CMD_INV, 32'hffff_fff9, 32'd0);
    issue_word(CMD_POW, 32'd0, 32'd0);
    issue_word(CMD_POW, 32'd6, 32'hffff_ffff);
    issue_word(CMD_POW, 32'd5, 32'h8000_0000);
    issue_word(CMD_SPARE_LO, 32'd5, 32'd3);
    issue_word(CMD_SPARE_HI, 32'hffff_ffff, 32'hffff_ffff);
    // largest modulus
    load_modulus(32'hffff_ffff);
    issue_word(CMD_MUL, 32'hffff_ffff, 32'h8000_0000);
    issue_word(CMD_POW, 32'h7fff_ffff, 32'h7fff_ffff);
    issue_word(CMD_POW, 32'd2, 32'h8000_0000);
    issue_word(CMD_INV, 32'd7, 32'd0);
    // written values below two act as two
    load_modulus(32'd0);
    issue_word(CMD_ADD, 32'd1, 32'd1);
    issue_word(CMD_POW, 32'd3, 32'hffff_fffd);
    load_modulus(32'd1);
    issue_word(CMD_SUB, 32'd0, 32'd1);

    // random words, modulus changes every so often
    for (int n = 0; n < 250; n++) begin
      if (n % 35 == 0) load_modulus(pick_modulus());
      no_gaps = (n >= 100 && n < 150);
      c = ($urandom_range(15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      issue_word(c, pick_operand(), pick_operand());
    end
    start <= 1'b0;

    guard = 0;
    while (words_pending != 0 && guard < 200_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("modular_arithmetic_unit_top_tb passed");
    end else begin
      $display("modular_arithmetic_unit_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mau_pkg.sv
design/modular_arithmetic_unit_top.sv
dv/modular_arithmetic_unit_checker.sv
dv/modular_arithmetic_unit_top_tb.sv
